>>> sv/crc16aug_pkg.sv
package crc16aug_pkg;

  // Field widths of the datapath.
  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_INDEX_W = 1;

  // Reset contents of the configuration registers.
  localparam logic [CRC_W-1:0] INIT_RESET = 16'h0000;
  localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL    = 1'b1;

  // Shifts one byte into the remainder, MSB first. A bit that leaves the top
  // of the remainder folds the polynomial back in.
  function automatic logic [CRC_W-1:0] crc_shift_byte(
    input logic [CRC_W-1:0]  r_in,
    input logic [BYTE_W-1:0] b,
    input logic [CRC_W-1:0]  poly
  );
    logic [CRC_W-1:0] r;
    logic             carry;
    r = r_in;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      carry = r[CRC_W-1];
      r = {r[CRC_W-2:0], b[k]};
      if (carry) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

>>> sv/crc16_augmented_byte_stream_core.sv
// Path: the last beat of a message passes the input register and two
// augmentation stages before its result is loaded into the output register.
// Throughput: one input beat per cycle while in_ready is high; the 8-step byte
// update into the running remainder is a combinational loop through the remainder register.
// Reset: rst (synchronous) clears all valid flags, the message state and the
// remainder, and loads initial_value = 0x0000 and polynomial = 0x1021.
module crc16_augmented_byte_stream_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [crc16aug_pkg::BYTE_W-1:0]       data_byte,
  input  logic                                  carries_byte,
  input  logic                                  last_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [crc16aug_pkg::CRC_W-1:0]        crc_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crc16aug_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crc16aug_pkg::CRC_W-1:0]        cfg_data
);
  import crc16aug_pkg::*;

  // Configuration registers.
  logic [CRC_W-1:0] initial_value;
  logic [CRC_W-1:0] polynomial;

  // Input register.
  logic              s0_valid;
  logic [BYTE_W-1:0] s0_byte;
  logic              s0_carries;
  logic              s0_last;

  // Running message state.
  logic [CRC_W-1:0] remainder;
  logic             in_message;

  // Augmentation stages and output register.
  logic             s1_valid;
  logic [CRC_W-1:0] s1_rem;
  logic             s2_valid;
  logic [CRC_W-1:0] s2_rem;

  logic             out_load;
  logic             s2_load_ok;
  logic             s1_load_ok;
  logic             s0_go;
  logic             s0_to_s1;
  logic [CRC_W-1:0] start_rem;
  logic [CRC_W-1:0] rem_next;
  logic [CRC_W-1:0] s2_rem_next;
  logic [CRC_W-1:0] aug_rem;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= INIT_RESET;
      polynomial    <= POLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INITIAL_VALUE: initial_value <= cfg_data;
        REG_POLYNOMIAL:    polynomial    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Each stage loads when it is empty or its contents move on this cycle.
  assign out_load   = s2_valid && (!out_valid || out_ready);
  assign s2_load_ok = !s2_valid || out_load;
  assign s1_load_ok = !s1_valid || s2_load_ok;
  // A beat that is not the last one ends in the remainder and needs no slot.
  assign s0_go      = s0_valid && (!s0_last || s1_load_ok);
  assign s0_to_s1   = s0_go && s0_last;
  assign in_ready   = !s0_valid || s0_go;

  // Byte update of the running remainder.
  always_comb begin
    start_rem = in_message ? remainder : initial_value;
    rem_next  = s0_carries ? crc_shift_byte(start_rem, s0_byte, polynomial) : start_rem;
  end

  // Augmentation: sixteen zero bits, eight in each stage.
  assign s2_rem_next = crc_shift_byte(s1_rem, '0, polynomial);
  assign aug_rem     = crc_shift_byte(s2_rem, '0, polynomial);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s0_byte    <= data_byte;
      s0_carries <= carries_byte;
      s0_last    <= last_item;
    end
  end

  // Message state: the last beat hands its remainder on and restarts.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      remainder  <= INIT_RESET;
    end else if (s0_go) begin
      in_message <= !s0_last;
      remainder  <= rem_next;
    end
  end

  // First augmentation stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load_ok) begin
      s1_valid <= s0_to_s1;
    end
    if (s0_to_s1) begin
      s1_rem <= rem_next;
    end
  end

  // Second augmentation stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load_ok) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && s2_load_ok) begin
      s2_rem <= s2_rem_next;
    end
  end

  // Output register, bytes swapped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s2_valid;
    end
    if (out_load) begin
      crc_value <= {aug_rem[BYTE_W-1:0], aug_rem[CRC_W-1:BYTE_W]};
    end
  end

  // A beat that does not end the message leaves the block inside a message.
  a_mid_message: assert property (@(posedge clk) disable iff (rst)
    (s0_go && !s0_last) |=> in_message)
    else $error("message state not set after a middle beat");

  // The last beat restarts the message and occupies the first stage.
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    s0_to_s1 |=> (s1_valid && !in_message))
    else $error("last beat lost or message state not cleared");

  // A stalled first stage keeps its remainder.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load_ok) |=> (s1_valid && $stable(s1_rem)))
    else $error("first augmentation stage changed while stalled");

  // No beat enters the input register while a stalled one sits there.
  a_s0_hold: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && !s0_go) |-> !in_ready)
    else $error("input register overwritten while stalled");

endmodule

>>> verif/crc16_stream_checker.sv
// Watches the input, result and register-write channels of the CRC core,
// keeps its own running remainder and register copies, and compares every
// result beat against the oldest predicted CRC.
module crc16_stream_checker
  import crc16aug_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   carries_byte,
  input  logic                   last_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [CRC_W-1:0]       crc_value,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]       cfg_data,
  output int                     mismatch_count,
  output int                     pending_count,
  output int                     results_checked
);

  // Shadow copies of the registers and of the message state.
  logic [CRC_W-1:0] seed_value;
  logic [CRC_W-1:0] gen_poly;
  logic [CRC_W-1:0] running_rem;
  logic [CRC_W-1:0] augmented;
  logic [CRC_W-1:0] expected_crc;
  logic             msg_open;
  logic [CRC_W-1:0] crc_expected_q[$];
  int               fails;
  int               checked;

  // Folds one byte into the remainder, MSB first; a bit leaving the top
  // brings the polynomial back in.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] rem,
                                                  input logic [BYTE_W-1:0] b,
                                                  input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] acc;
    acc = rem;
    for (int i = BYTE_W - 1; i >= 0; i--)
      acc = {acc[CRC_W-2:0], b[i]} ^ (acc[CRC_W-1] ? poly : '0);
    return acc;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seed_value  = INIT_RESET;
      gen_poly    = POLY_RESET;
      running_rem = INIT_RESET;
      msg_open    = 1'b0;
      crc_expected_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      // Register writes are for the user to make only while the core is idle; the core itself does not enforce this.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INITIAL_VALUE: seed_value = cfg_data;
          REG_POLYNOMIAL:    gen_poly   = cfg_data;
          default: ;
        endcase
      end

      // Compare each result beat with the oldest expectation.
      if (out_valid && out_ready) begin
        if (crc_expected_q.size() == 0) begin
          $error("crc_value: expected none, actual %h", crc_value);
          fails++;
        end else begin
          expected_crc = crc_expected_q.pop_front();
          checked++;
          if (crc_value !== expected_crc) begin
            $error("crc_value: expected %h, actual %h", expected_crc, crc_value);
            fails++;
          end
        end
      end

      // Advance the predicted remainder on every accepted input beat.
      if (in_valid && in_ready) begin
        if (!msg_open)
          running_rem = seed_value;
        if (carries_byte)
          running_rem = fold_byte(running_rem, data_byte, gen_poly);
        if (last_item) begin
          augmented = fold_byte(fold_byte(running_rem, '0, gen_poly), '0, gen_poly);
          crc_expected_q.push_back({augmented[7:0], augmented[15:8]});
          msg_open    = 1'b0;
          running_rem = seed_value;
        end else begin
          msg_open = 1'b1;
        end
      end
    end
    mismatch_count  <= fails;
    pending_count   <= crc_expected_q.size();
    results_checked <= checked;
  end

endmodule

>>> verif/testbench.sv
module testbench;
  import crc16aug_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 5;
  localparam int PHASE_BEATS  = 150;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      data_byte = '0;
  logic                   carries_byte = 1'b0;
  logic                   last_item = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CRC_W-1:0]       crc_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CRC_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int beats_sent  = 0;
  int reg_writes  = 0;
  bit calm        = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crc16_augmented_byte_stream_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .carries_byte (carries_byte),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .crc_value    (crc_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  crc16_stream_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .carries_byte    (carries_byte),
    .last_item       (last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crc_value       (crc_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  // The result side stalls now and then, except during the calm phase.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  // Presents one input beat, with an occasional one-cycle gap ahead of it, and
  // returns at the edge where it is accepted.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic c, input logic l);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    carries_byte <= c;
    last_item    <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CRC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Waits until every predicted CRC has come back, then lets the pipeline
  // settle so that an open message has reached the remainder.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CRC_W-1:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return CRC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int   bytes_left;
    bit   tail_empty;
    bit   msg_open;
    logic ends_msg;
    bytes_left = 0;
    tail_empty = 1'b0;
    msg_open   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default registers, empty message, byte extremes, and empty
    // items in the middle and at the end of a message.
    send_beat(8'hA7, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);

    // Directed: all-ones registers.
    wait_idle();
    write_reg(REG_INITIAL_VALUE, 16'hFFFF);
    write_reg(REG_POLYNOMIAL, 16'hFFFF);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b1);

    // Directed: all-zero registers.
    wait_idle();
    write_reg(REG_INITIAL_VALUE, 16'h0000);
    write_reg(REG_POLYNOMIAL, 16'h0000);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b1);

    // Directed: registers rewritten in the middle of a message. The new
    // polynomial applies at once, the new seed only from the next message.
    wait_idle();
    write_reg(REG_POLYNOMIAL, 16'h8005);
    write_reg(REG_INITIAL_VALUE, 16'h1D0F);
    send_beat(8'h31, 1'b1, 1'b0);
    send_beat(8'h32, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_POLYNOMIAL, 16'h1021);
    write_reg(REG_INITIAL_VALUE, 16'hABCD);
    send_beat(8'h33, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);

    // Random: short messages with stray empty items; a phase may end inside
    // a message, so the next register writes land mid-message too.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_reg(REG_INITIAL_VALUE, pick_word());
      write_reg(REG_POLYNOMIAL, pick_word());
      calm = (phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (!msg_open) begin
          bytes_left = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          tail_empty = (bytes_left == 0) || ($urandom_range(6) == 0);
          msg_open   = 1'b1;
        end
        if (bytes_left != 0 && $urandom_range(99) < 8) begin
          send_beat(pick_byte(), 1'b0, 1'b0);
        end else if (bytes_left != 0) begin
          bytes_left--;
          ends_msg = (bytes_left == 0) && !tail_empty;
          send_beat(pick_byte(), 1'b1, ends_msg);
          msg_open = !ends_msg;
        end else begin
          send_beat(pick_byte(), 1'b0, 1'b1);
          msg_open = 1'b0;
        end
      end
    end
    calm = 1'b0;

    // Close any open message so its CRC is checked too.
    send_beat(pick_byte(), 1'b0, 1'b1);
    wait_idle();

    $display("summary: %0d input beats, %0d CRC results checked, %0d register writes",
             beats_sent, results_checked, reg_writes);
    $display("summary: seeds and polynomials at both extremes, empty messages, and writes",
             " inside open messages were covered");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/crc16aug_pkg.sv
sv/crc16_augmented_byte_stream_core.sv
verif/crc16_stream_checker.sv
verif/testbench.sv
